/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the filter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rsvf_pkg.sv */
// ----------------------------------------------------------------------------
// rsvf_pkg
// Widths, coefficient indexes and saturation helpers of the ramped SVF.
// ----------------------------------------------------------------------------
package rsvf_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 24;
   localparam int DELTA_W   = COEF_W + 1;
   localparam int RAMP_W    = COEF_W + 2;
   localparam int INT_W     = 32;
   localparam int LEN_W     = 6;
   localparam int FRAC      = 20;
   localparam int VAL_W     = 40;
   localparam int PART_W    = FRAC + 1;
   localparam int PP_W      = COEF_W + 1 + PART_W;
   localparam int ACC_W     = 64;
   localparam int RES_W     = ACC_W - FRAC;
   localparam int SUM_W     = RES_W + 2;
   localparam int NUM_CH    = 2;
   localparam int CH_IDX_W  = $clog2(NUM_CH);
   localparam int NCOEF     = 4;
   localparam int K_W       = $clog2(NCOEF);
   localparam int CHUNK_MAX = 32;
   localparam int DIV_CNT_W = $clog2(COEF_W);

   localparam logic [K_W-1:0] COEF_G     = K_W'(0);
   localparam logic [K_W-1:0] COEF_HP    = K_W'(1);
   localparam logic [K_W-1:0] COEF_FB    = K_W'(2);
   localparam logic [K_W-1:0] COEF_SCALE = K_W'(3);

   typedef struct packed {
      logic en;
      logic high;
   } mac_ctrl_type;

   function automatic logic signed [INT_W-1:0] sat_int(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:INT_W-1] == {(SUM_W-INT_W+1){v[SUM_W-1]}});
      if (fits) begin
         return v[INT_W-1:0];
      end
      return {v[SUM_W-1], {(INT_W-1){~v[SUM_W-1]}}};
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
      logic fits;
      fits = (v[RES_W-1:SAMPLE_W-1] == {(RES_W-SAMPLE_W+1){v[RES_W-1]}});
      if (fits) begin
         return v[SAMPLE_W-1:0];
      end
      return {v[RES_W-1], {(SAMPLE_W-1){~v[RES_W-1]}}};
   endfunction

endpackage

/* hdl/rsvf_if.sv */
// ----------------------------------------------------------------------------
// rsvf_req_if / rsvf_rsp_if
// Valid/ready channels carrying filter input items and output samples.
// ----------------------------------------------------------------------------
interface rsvf_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [rsvf_pkg::SAMPLE_W-1:0] sample_in;
   logic                               channel;
   logic                               chunk_start;
   logic [rsvf_pkg::LEN_W-1:0]         chunk_length;
   logic [rsvf_pkg::COEF_W-1:0]        target_g;
   logic [rsvf_pkg::COEF_W-1:0]        target_hp_norm;
   logic [rsvf_pkg::COEF_W-1:0]        target_feedback;
   logic [rsvf_pkg::COEF_W-1:0]        target_out_scale;

   modport source (output valid, sample_in, channel, chunk_start, chunk_length,
                   target_g, target_hp_norm, target_feedback, target_out_scale,
                   input ready);
   modport sink   (input valid, sample_in, channel, chunk_start, chunk_length,
                   target_g, target_hp_norm, target_feedback, target_out_scale,
                   output ready);
endinterface

interface rsvf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rsvf_pkg::SAMPLE_W-1:0] sample_out;
   logic                               channel_out;

   modport source (output valid, sample_out, channel_out, input ready);
   modport sink   (input valid, sample_out, channel_out, output ready);
endinterface

/* hdl/rsvf_mac.sv */
// ----------------------------------------------------------------------------
// rsvf_mac
// Shared coefficient multiplier: Q4.20 times a 40-bit value in two partial
// products (low 20 bits, then signed high part), rounded result >> 20.
// ----------------------------------------------------------------------------
module rsvf_mac (
   input  logic                                clock,
   input  rsvf_pkg::mac_ctrl_type              ctrl,
   input  logic [rsvf_pkg::COEF_W-1:0]         coef,
   input  logic signed [rsvf_pkg::VAL_W-1:0]   val,
   output logic signed [rsvf_pkg::RES_W-1:0]   res
);

   localparam logic signed [rsvf_pkg::ACC_W-1:0] ROUND =
      rsvf_pkg::ACC_W'(1) <<< (rsvf_pkg::FRAC - 1);

   logic signed [rsvf_pkg::PART_W-1:0] part;
   logic signed [rsvf_pkg::PP_W-1:0]   pp;
   logic signed [rsvf_pkg::ACC_W-1:0]  pp_ext;
   logic signed [rsvf_pkg::ACC_W-1:0]  acc_in;
   logic signed [rsvf_pkg::ACC_W-1:0]  acc_ff;

   assign part = ctrl.high ? {val[rsvf_pkg::VAL_W-1], val[rsvf_pkg::VAL_W-1:rsvf_pkg::FRAC]}
                           : {1'b0, val[rsvf_pkg::FRAC-1:0]};
   assign pp     = $signed({1'b0, coef}) * part;
   assign pp_ext = rsvf_pkg::ACC_W'(pp);
   assign acc_in = ctrl.high ? acc_ff + (pp_ext <<< rsvf_pkg::FRAC) : pp_ext + ROUND;
   assign res    = acc_ff[rsvf_pkg::ACC_W-1:rsvf_pkg::FRAC];

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* hdl/rsvf_div.sv */
// ----------------------------------------------------------------------------
// rsvf_div
// Radix-2 restoring divider for coefficient deltas: signed 25-bit dividend by
// a chunk length of 1..32, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rsvf_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [rsvf_pkg::DELTA_W-1:0]   dividend,
   input  logic [rsvf_pkg::LEN_W-1:0]            divisor,
   output logic                                  done,
   output logic signed [rsvf_pkg::DELTA_W-1:0]   quotient
);

   localparam logic [rsvf_pkg::DIV_CNT_W-1:0] LAST = rsvf_pkg::DIV_CNT_W'(rsvf_pkg::COEF_W - 1);

   logic                                 busy_ff;
   logic                                 done_ff;
   logic                                 neg_ff;
   logic [rsvf_pkg::DIV_CNT_W-1:0]       cnt_ff;
   logic [rsvf_pkg::LEN_W-2:0]           rem_ff;
   logic [rsvf_pkg::LEN_W-1:0]           div_ff;
   logic [rsvf_pkg::COEF_W-1:0]          q_ff;
   logic signed [rsvf_pkg::DELTA_W-1:0]  mag_full;
   logic [rsvf_pkg::LEN_W-1:0]           trial;
   logic                                 fit;
   logic [rsvf_pkg::LEN_W-1:0]           trial_sub;
   logic [rsvf_pkg::DELTA_W-1:0]         q_ext;

   assign mag_full  = dividend[rsvf_pkg::DELTA_W-1] ? -dividend : dividend;
   assign trial     = {rem_ff, q_ff[rsvf_pkg::COEF_W-1]};
   assign fit       = (trial >= div_ff);
   assign trial_sub = trial - div_ff;
   assign q_ext     = {1'b0, q_ff};
   assign quotient  = neg_ff ? -$signed(q_ext) : $signed(q_ext);
   assign done      = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            div_ff  <= divisor;
            neg_ff  <= dividend[rsvf_pkg::DELTA_W-1];
            q_ff    <= mag_full[rsvf_pkg::COEF_W-1:0];
         end else if (busy_ff) begin
            rem_ff <= fit ? trial_sub[rsvf_pkg::LEN_W-2:0] : trial[rsvf_pkg::LEN_W-2:0];
            q_ff   <= {q_ff[rsvf_pkg::COEF_W-2:0], fit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

/* hdl/ramped_svf_bandpass_top.sv */
// ----------------------------------------------------------------------------
// ramped_svf_bandpass_top
// Two-channel ZDF state-variable bandpass with linearly ramped coefficients,
// run by a sequencer over one shared multiplier and a bit-serial divider.
//
//   Channel   Dir  Handshake        Payload
//   req_chan  in   valid / ready    sample, channel, chunk start/length, targets
//   rsp_chan  out  valid / ready    sample_out, channel_out
//
// Plain item: after the input transfer come 4 ramp steps, 5 products of two
// multiplier passes each, 6 sum steps and the output step; the next input
// transfer is taken only once the block is back in idle.
// Chunk-start item: four divisions come first (24 quotient bits each).
// Ready only while idle; the result register frees the input side, a second
// result waits in its final step until the first is taken.
// Reset is synchronous and clears all filter state to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ramped_svf_bandpass_top (
   input  logic       clock,
   input  logic       reset,
   rsvf_req_if.sink   req_chan,
   rsvf_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_START, S_DIV_WAIT, S_RAMP, S_MUL_LO, S_MUL_HI, S_POST, S_POST2, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_FB, OP_HP, OP_GHP, OP_GBP, OP_OUT
   } op_type;

   localparam int SW = rsvf_pkg::SUM_W;
   localparam logic [rsvf_pkg::K_W-1:0] K_LAST = rsvf_pkg::K_W'(rsvf_pkg::NCOEF - 1);
   localparam logic [rsvf_pkg::COEF_W-1:0] COEF_MAX = '1;

   state_type state_ff;
   op_type    op_ff;
   logic [rsvf_pkg::K_W-1:0]       k_ff;
   logic [rsvf_pkg::CH_IDX_W-1:0]  ch_ff;
   logic                           chin_ff;
   logic [rsvf_pkg::LEN_W-1:0]     len_ff;
   logic signed [rsvf_pkg::SAMPLE_W-1:0] x_ff;
   logic [rsvf_pkg::COEF_W-1:0]    tgt_ff [rsvf_pkg::NCOEF];

   logic [rsvf_pkg::COEF_W-1:0]          held_ff  [rsvf_pkg::NUM_CH][rsvf_pkg::NCOEF];
   logic [rsvf_pkg::COEF_W-1:0]          run_ff   [rsvf_pkg::NUM_CH][rsvf_pkg::NCOEF];
   logic signed [rsvf_pkg::DELTA_W-1:0]  delta_ff [rsvf_pkg::NUM_CH][rsvf_pkg::NCOEF];
   logic signed [rsvf_pkg::INT_W-1:0]    s1_ff    [rsvf_pkg::NUM_CH];
   logic signed [rsvf_pkg::INT_W-1:0]    s2_ff    [rsvf_pkg::NUM_CH];

   logic signed [rsvf_pkg::VAL_W-1:0]  v_ff;
   logic signed [rsvf_pkg::INT_W-1:0]  hp_ff;
   logic signed [rsvf_pkg::INT_W-1:0]  bp_ff;
   logic signed [rsvf_pkg::INT_W-1:0]  lp_ff;
   logic signed [rsvf_pkg::RES_W-1:0]  gx_ff;

   logic                               rsp_valid_ff;
   logic signed [rsvf_pkg::SAMPLE_W-1:0] sample_out_ff;
   logic                               channel_out_ff;

   logic [rsvf_pkg::LEN_W-1:0]          len_in;
   rsvf_pkg::mac_ctrl_type              mac_ctrl;
   logic [rsvf_pkg::COEF_W-1:0]         mac_coef;
   logic signed [rsvf_pkg::VAL_W-1:0]   mac_val;
   logic signed [rsvf_pkg::RES_W-1:0]   mac_res;
   logic                                div_start;
   logic                                div_done;
   logic signed [rsvf_pkg::DELTA_W-1:0] div_dividend;
   logic signed [rsvf_pkg::DELTA_W-1:0] div_quot;
   logic signed [rsvf_pkg::RAMP_W-1:0]  ramp_sum;
   logic [rsvf_pkg::COEF_W-1:0]         ramp_in;
   logic signed [SW-1:0]                v_in;
   logic                                rsp_free;
   logic                                ramp_last;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sample_out  = sample_out_ff;
   assign rsp_chan.channel_out = channel_out_ff;
   assign rsp_free             = !rsp_valid_ff || rsp_chan.ready;
   assign ramp_last            = (state_ff == S_RAMP) && (k_ff == K_LAST);

   always_comb begin
      len_in = req_chan.chunk_length;
      if (req_chan.chunk_length == '0) begin
         len_in = rsvf_pkg::LEN_W'(1);
      end else if (req_chan.chunk_length > rsvf_pkg::LEN_W'(rsvf_pkg::CHUNK_MAX)) begin
         len_in = rsvf_pkg::LEN_W'(rsvf_pkg::CHUNK_MAX);
      end
   end

   assign div_start    = (state_ff == S_DIV_START);
   assign div_dividend = $signed({1'b0, tgt_ff[k_ff]}) - $signed({1'b0, held_ff[ch_ff][k_ff]});

   assign ramp_sum = $signed({2'b00, run_ff[ch_ff][k_ff]})
                   + rsvf_pkg::RAMP_W'(delta_ff[ch_ff][k_ff]);
   always_comb begin
      if (ramp_sum[rsvf_pkg::RAMP_W-1]) begin
         ramp_in = '0;
      end else if (ramp_sum[rsvf_pkg::COEF_W]) begin
         ramp_in = COEF_MAX;
      end else begin
         ramp_in = ramp_sum[rsvf_pkg::COEF_W-1:0];
      end
   end

   assign mac_ctrl.en   = (state_ff == S_MUL_LO) || (state_ff == S_MUL_HI);
   assign mac_ctrl.high = (state_ff == S_MUL_HI);

   always_comb begin
      case (op_ff)
         OP_FB: begin
            mac_coef = run_ff[ch_ff][rsvf_pkg::COEF_FB];
            mac_val  = rsvf_pkg::VAL_W'(s1_ff[ch_ff]);
         end
         OP_HP: begin
            mac_coef = run_ff[ch_ff][rsvf_pkg::COEF_HP];
            mac_val  = v_ff;
         end
         OP_GHP: begin
            mac_coef = run_ff[ch_ff][rsvf_pkg::COEF_G];
            mac_val  = rsvf_pkg::VAL_W'(hp_ff);
         end
         OP_GBP: begin
            mac_coef = run_ff[ch_ff][rsvf_pkg::COEF_G];
            mac_val  = rsvf_pkg::VAL_W'(bp_ff);
         end
         default: begin
            mac_coef = run_ff[ch_ff][rsvf_pkg::COEF_SCALE];
            mac_val  = rsvf_pkg::VAL_W'(bp_ff);
         end
      endcase
   end

   assign v_in = SW'(x_ff) - SW'(mac_res) - SW'(s2_ff[ch_ff]);

   rsvf_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .coef  (mac_coef),
      .val   (mac_val),
      .res   (mac_res)
   );

   rsvf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_FB;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < rsvf_pkg::NUM_CH; c++) begin
            s1_ff[c] <= '0;
            s2_ff[c] <= '0;
            for (int k = 0; k < rsvf_pkg::NCOEF; k++) begin
               held_ff[c][k]  <= '0;
               run_ff[c][k]   <= '0;
               delta_ff[c][k] <= '0;
            end
         end
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  x_ff      <= req_chan.sample_in;
                  chin_ff   <= req_chan.channel;
                  ch_ff     <= rsvf_pkg::CH_IDX_W'(req_chan.channel % rsvf_pkg::NUM_CH);
                  len_ff    <= len_in;
                  tgt_ff[rsvf_pkg::COEF_G]     <= req_chan.target_g;
                  tgt_ff[rsvf_pkg::COEF_HP]    <= req_chan.target_hp_norm;
                  tgt_ff[rsvf_pkg::COEF_FB]    <= req_chan.target_feedback;
                  tgt_ff[rsvf_pkg::COEF_SCALE] <= req_chan.target_out_scale;
                  k_ff      <= '0;
                  op_ff     <= OP_FB;
                  state_ff  <= req_chan.chunk_start ? S_DIV_START : S_RAMP;
               end
            end
            S_DIV_START: begin
               run_ff[ch_ff][k_ff]  <= held_ff[ch_ff][k_ff];
               held_ff[ch_ff][k_ff] <= tgt_ff[k_ff];
               state_ff             <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  delta_ff[ch_ff][k_ff] <= div_quot;
                  k_ff                  <= k_ff + 1'b1;
                  state_ff              <= (k_ff == K_LAST) ? S_RAMP : S_DIV_START;
               end
            end
            S_RAMP: begin
               run_ff[ch_ff][k_ff] <= ramp_in;
               k_ff                <= k_ff + 1'b1;
               if (k_ff == K_LAST) begin
                  state_ff <= S_MUL_LO;
               end
            end
            S_MUL_LO: begin
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               state_ff <= (op_ff == OP_OUT) ? S_DONE : S_POST;
            end
            S_POST: begin
               case (op_ff)
                  OP_FB: begin
                     v_ff     <= v_in[rsvf_pkg::VAL_W-1:0];
                     op_ff    <= OP_HP;
                     state_ff <= S_MUL_LO;
                  end
                  OP_HP: begin
                     hp_ff    <= rsvf_pkg::sat_int(SW'(mac_res));
                     op_ff    <= OP_GHP;
                     state_ff <= S_MUL_LO;
                  end
                  OP_GHP: begin
                     gx_ff    <= mac_res;
                     bp_ff    <= rsvf_pkg::sat_int(SW'(mac_res) + SW'(s1_ff[ch_ff]));
                     state_ff <= S_POST2;
                  end
                  default: begin
                     gx_ff    <= mac_res;
                     lp_ff    <= rsvf_pkg::sat_int(SW'(mac_res) + SW'(s2_ff[ch_ff]));
                     state_ff <= S_POST2;
                  end
               endcase
            end
            S_POST2: begin
               if (op_ff == OP_GHP) begin
                  s1_ff[ch_ff] <= rsvf_pkg::sat_int(SW'(gx_ff) + SW'(bp_ff));
                  op_ff        <= OP_GBP;
               end else begin
                  s2_ff[ch_ff] <= rsvf_pkg::sat_int(SW'(gx_ff) + SW'(lp_ff));
                  op_ff        <= OP_OUT;
               end
               state_ff <= S_MUL_LO;
            end
            S_DONE: begin
               if (rsp_free) begin
                  sample_out_ff  <= rsvf_pkg::sat_out(mac_res);
                  channel_out_ff <= chin_ff;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `ASSERT_IMPLIES(a_div_done_wait, clock, reset, div_done, state_ff == S_DIV_WAIT, "stray done")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, state_ff == S_DONE && !rsp_free, state_ff == S_DONE, "lost")
   `ASSERT_NEXT(a_ramp_to_mul, clock, reset, ramp_last, state_ff == S_MUL_LO && op_ff == OP_FB, "no mul")

endmodule

/* verif/tb_ramped_svf_bandpass_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ramped_svf_bandpass_top
// Self-checking bench for the ramped two-channel SVF bandpass. A table of
// directed items goes first (reset state, field extremes, odd chunk lengths,
// coefficient clamping, saturation), then random chunk sequences per
// channel with some noise. Every output transfer is checked against an
// in-bench bit-exact model of the filter (or a fixed row value), with random
// stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_ramped_svf_bandpass_top;

   localparam int     DIRECTED_ROWS = 25;
   localparam int     RANDOM_ITEMS  = 1800;
   localparam int     HOLD_OFF      = 400;
   localparam int     IDLE_LIMIT    = 4000;
   localparam int     DRAIN_CYCLES  = 200;
   localparam longint COEF_TOP      = (longint'(1) <<< rsvf_pkg::COEF_W) - 1;
   localparam longint ACC_MAX       = (longint'(1) <<< (rsvf_pkg::INT_W - 1)) - 1;
   localparam longint ACC_MIN       = -(longint'(1) <<< (rsvf_pkg::INT_W - 1));
   localparam longint OUT_MAX       = (longint'(1) <<< (rsvf_pkg::SAMPLE_W - 1)) - 1;
   localparam longint OUT_MIN       = -(longint'(1) <<< (rsvf_pkg::SAMPLE_W - 1));

   typedef struct packed {
      logic signed [rsvf_pkg::SAMPLE_W-1:0] sample_in;
      logic                                 channel;
      logic                                 chunk_start;
      logic [rsvf_pkg::LEN_W-1:0]           chunk_length;
      logic [rsvf_pkg::COEF_W-1:0]          target_g;
      logic [rsvf_pkg::COEF_W-1:0]          target_hp_norm;
      logic [rsvf_pkg::COEF_W-1:0]          target_feedback;
      logic [rsvf_pkg::COEF_W-1:0]          target_out_scale;
   } filt_item_type;

   typedef struct packed {
      logic signed [rsvf_pkg::SAMPLE_W-1:0] sample_out;
      logic                                 channel_out;
   } filt_out_type;

   typedef struct packed {
      filt_item_type                        item;
      logic                                 fixed_out;
      logic signed [rsvf_pkg::SAMPLE_W-1:0] out_value;
   } dir_row_type;

   // fixed_out rows carry an output known without the model (zero scale)
   localparam dir_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{24'h7FFFFF, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b1, 24'h000000},
      '{'{24'h800000, 1'b1, 1'b0, 6'd63, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
        1'b1, 24'h000000},
      '{'{24'h7FFFFF, 1'b0, 1'b1, 6'd1,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b1, 24'h000000},
      '{'{24'h7FFFFF, 1'b1, 1'b1, 6'd1,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000},
        1'b1, 24'h000000},
      '{'{24'h800000, 1'b1, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h7FFFFF, 1'b1, 1'b1, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b1, 24'h000000},
      '{'{24'h000000, 1'b1, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b1, 24'h000000},
      '{'{24'h400000, 1'b0, 1'b1, 6'd63, 24'h01999A, 24'h0E0000, 24'h170000, 24'h100000},
        1'b0, 24'h000000},
      '{'{24'h000001, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'hFFFFFF, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h7FFFFF, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h800000, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h123456, 1'b0, 1'b1, 6'd33, 24'h000000, 24'h100000, 24'h100000, 24'h080000},
        1'b0, 24'h000000},
      '{'{24'h7FFFFF, 1'b0, 1'b1, 6'd32, 24'h080000, 24'h0C0000, 24'h0A0000, 24'hFFFFFF},
        1'b0, 24'h000000},
      '{'{24'h7FFFFF, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h7FFFFF, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h7FFFFF, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h3A5C00, 1'b1, 1'b1, 6'd4,  24'h040000, 24'h0D0000, 24'h0C0000, 24'h200000},
        1'b0, 24'h000000},
      '{'{24'h800000, 1'b1, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h7FFFFF, 1'b1, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h000000, 1'b1, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h555555, 1'b1, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'hAAAAAA, 1'b1, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000},
      '{'{24'h800000, 1'b0, 1'b1, 6'd2,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
        1'b0, 24'h000000},
      '{'{24'h800000, 1'b0, 1'b0, 6'd0,  24'h000000, 24'h000000, 24'h000000, 24'h000000},
        1'b0, 24'h000000}
   };

   logic clock;
   logic reset;

   rsvf_req_if req_chan ();
   rsvf_rsp_if rsp_chan ();

   ramped_svf_bandpass_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // filter model state
   logic [rsvf_pkg::COEF_W-1:0]         held_coef [rsvf_pkg::NUM_CH][rsvf_pkg::NCOEF];
   logic [rsvf_pkg::COEF_W-1:0]         run_coef  [rsvf_pkg::NUM_CH][rsvf_pkg::NCOEF];
   logic signed [rsvf_pkg::DELTA_W-1:0] step_coef [rsvf_pkg::NUM_CH][rsvf_pkg::NCOEF];
   logic signed [rsvf_pkg::INT_W-1:0]   integ_one [rsvf_pkg::NUM_CH];
   logic signed [rsvf_pkg::INT_W-1:0]   integ_two [rsvf_pkg::NUM_CH];

   filt_out_type bp_expected [$];
   int           mismatch_count = 0;
   int           items_sent     = 0;
   int           results_taken  = 0;
   int           idle_cycles    = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint clip_range(longint v, longint lo, longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // Q4.20 coefficient times value, rounded back to the value's scale
   function automatic longint round_mul(longint coef, longint val);
      return (coef * val + (longint'(1) <<< (rsvf_pkg::FRAC - 1))) >>> rsvf_pkg::FRAC;
   endfunction

   function automatic filt_out_type predict_bandpass(filt_item_type it);
      logic [rsvf_pkg::COEF_W-1:0] tgt [rsvf_pkg::NCOEF];
      longint                      coef [rsvf_pkg::NCOEF];
      longint                      len, x, s1, s2, hp, ghp, bp, gbp, lp;
      int                          ch;
      int                          k;
      filt_out_type                res;
      ch = int'(it.channel) % rsvf_pkg::NUM_CH;
      tgt[rsvf_pkg::COEF_G]     = it.target_g;
      tgt[rsvf_pkg::COEF_HP]    = it.target_hp_norm;
      tgt[rsvf_pkg::COEF_FB]    = it.target_feedback;
      tgt[rsvf_pkg::COEF_SCALE] = it.target_out_scale;
      if (it.chunk_start) begin
         len = longint'(it.chunk_length);
         if (len < 1) begin
            len = 1;
         end
         if (len > rsvf_pkg::CHUNK_MAX) begin
            len = rsvf_pkg::CHUNK_MAX;
         end
         for (k = 0; k < rsvf_pkg::NCOEF; k++) begin
            step_coef[ch][k] =
               rsvf_pkg::DELTA_W'((longint'(tgt[k]) - longint'(held_coef[ch][k])) / len);
            run_coef[ch][k]  = held_coef[ch][k];
            held_coef[ch][k] = tgt[k];
         end
      end
      for (k = 0; k < rsvf_pkg::NCOEF; k++) begin
         run_coef[ch][k] = rsvf_pkg::COEF_W'(clip_range(longint'(run_coef[ch][k])
                                                        + longint'(step_coef[ch][k]),
                                                        0, COEF_TOP));
         coef[k] = longint'(run_coef[ch][k]);
      end
      x  = longint'(it.sample_in);
      s1 = longint'(integ_one[ch]);
      s2 = longint'(integ_two[ch]);
      hp  = clip_range(round_mul(coef[rsvf_pkg::COEF_HP],
                                 x - round_mul(coef[rsvf_pkg::COEF_FB], s1) - s2),
                       ACC_MIN, ACC_MAX);
      ghp = round_mul(coef[rsvf_pkg::COEF_G], hp);
      bp  = clip_range(ghp + s1, ACC_MIN, ACC_MAX);
      s1  = clip_range(ghp + bp, ACC_MIN, ACC_MAX);
      gbp = round_mul(coef[rsvf_pkg::COEF_G], bp);
      lp  = clip_range(gbp + s2, ACC_MIN, ACC_MAX);
      s2  = clip_range(gbp + lp, ACC_MIN, ACC_MAX);
      integ_one[ch] = rsvf_pkg::INT_W'(s1);
      integ_two[ch] = rsvf_pkg::INT_W'(s2);
      res.sample_out  = rsvf_pkg::SAMPLE_W'(clip_range(round_mul(coef[rsvf_pkg::COEF_SCALE], bp),
                                                       OUT_MIN, OUT_MAX));
      res.channel_out = it.channel;
      return res;
   endfunction

   // bursts of back-to-back traffic between stretches of random waits
   function automatic int draw_wait(int n);
      if ((n / 64) % 4 == 3) begin
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   task automatic send_item(input filt_item_type item);
      int gap;
      gap = draw_wait(items_sent);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.sample_in        <= item.sample_in;
      req_chan.channel          <= item.channel;
      req_chan.chunk_start      <= item.chunk_start;
      req_chan.chunk_length     <= item.chunk_length;
      req_chan.target_g         <= item.target_g;
      req_chan.target_hp_norm   <= item.target_hp_norm;
      req_chan.target_feedback  <= item.target_feedback;
      req_chan.target_out_scale <= item.target_out_scale;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   initial begin : stimulus
      filt_item_type item;
      filt_out_type  want;
      int            remaining [rsvf_pkg::NUM_CH];
      int            i, c, k, ch, len;
      longint        g, fb;
      reset = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.sample_in        = '0;
      req_chan.channel          = 1'b0;
      req_chan.chunk_start      = 1'b0;
      req_chan.chunk_length     = '0;
      req_chan.target_g         = '0;
      req_chan.target_hp_norm   = '0;
      req_chan.target_feedback  = '0;
      req_chan.target_out_scale = '0;
      for (c = 0; c < rsvf_pkg::NUM_CH; c++) begin
         integ_one[c] = '0;
         integ_two[c] = '0;
         remaining[c] = 0;
         for (k = 0; k < rsvf_pkg::NCOEF; k++) begin
            held_coef[c][k] = '0;
            run_coef[c][k]  = '0;
            step_coef[c][k] = '0;
         end
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(directed_rows[i].item);
         want = predict_bandpass(directed_rows[i].item);
         if (directed_rows[i].fixed_out) begin
            want.sample_out = directed_rows[i].out_value;
         end
         bp_expected.push_back(want);
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         item.sample_in        = rsvf_pkg::SAMPLE_W'($urandom());
         if ($urandom_range(0, 3) == 0) begin
            item.sample_in = item.sample_in >>> 8;
         end
         item.channel          = 1'($urandom_range(0, 1));
         item.chunk_length     = rsvf_pkg::LEN_W'($urandom());
         item.target_g         = rsvf_pkg::COEF_W'($urandom());
         item.target_hp_norm   = rsvf_pkg::COEF_W'($urandom());
         item.target_feedback  = rsvf_pkg::COEF_W'($urandom());
         item.target_out_scale = rsvf_pkg::COEF_W'($urandom());
         ch = int'(item.channel);
         if ($urandom_range(0, 99) < 12) begin
            item.chunk_start = 1'($urandom_range(0, 1));
         end else if (remaining[ch] == 0) begin
            item.chunk_start = 1'b1;
            if ($urandom_range(0, 9) != 0) begin
               item.chunk_length = rsvf_pkg::LEN_W'($urandom_range(1, rsvf_pkg::CHUNK_MAX));
            end
            len = int'(item.chunk_length);
            remaining[ch] = (len == 0) ? 0 :
                            ((len > rsvf_pkg::CHUNK_MAX) ? rsvf_pkg::CHUNK_MAX - 1 : len - 1);
            // mostly stable filter settings; the rest keep the random targets
            if ($urandom_range(0, 99) < 85) begin
               g  = longint'($urandom_range(24'h000400, 24'h300000));
               fb = g + longint'($urandom_range(24'h008000, 24'h400000));
               item.target_g         = rsvf_pkg::COEF_W'(g);
               item.target_feedback  = rsvf_pkg::COEF_W'(fb);
               item.target_hp_norm   = rsvf_pkg::COEF_W'(
                  (longint'(1) <<< (2 * rsvf_pkg::FRAC))
                  / ((longint'(1) <<< rsvf_pkg::FRAC) + ((g * fb) >>> rsvf_pkg::FRAC)));
               item.target_out_scale = rsvf_pkg::COEF_W'($urandom_range(0, 24'h300000));
            end
         end else begin
            item.chunk_start = 1'b0;
            remaining[ch]--;
         end
         send_item(item);
         bp_expected.push_back(predict_bandpass(item));
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (bp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** ramped_svf_bandpass_top: PASSED **");
      end else begin
         $display("** ramped_svf_bandpass_top: FAILED **");
      end
      $finish;
   end

   initial begin : output_side
      int  gap;
      bit  held_off;
      held_off = 1'b0;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         gap = draw_wait(results_taken);
         // one long stall so the block backs up into the input side
         if (!held_off && results_taken >= 150) begin
            held_off = 1'b1;
            gap = HOLD_OFF;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin : check_output
      filt_out_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_taken++;
         if (bp_expected.size() == 0) begin
            $display("%0t: unexpected transfer, sample_out %0d channel_out %0d",
                     $time, rsp_chan.sample_out, rsp_chan.channel_out);
            mismatch_count++;
         end else begin
            want = bp_expected.pop_front();
            if (rsp_chan.sample_out !== want.sample_out) begin
               $display("%0t: sample_out expected %0d, got %0d",
                        $time, want.sample_out, rsp_chan.sample_out);
               mismatch_count++;
            end
            if (rsp_chan.channel_out !== want.channel_out) begin
               $display("%0t: channel_out expected %0d, got %0d",
                        $time, want.channel_out, rsp_chan.channel_out);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, bp_expected.size());
         $display("** ramped_svf_bandpass_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* files.f */
+incdir+hdl
hdl/rsvf_pkg.sv
hdl/rsvf_if.sv
hdl/rsvf_mac.sv
hdl/rsvf_div.sv
hdl/ramped_svf_bandpass_top.sv
verif/tb_ramped_svf_bandpass_top.sv
